// ===== rtl/nearest_vector_search_core_defines.svh =====
// Assertion macros for the nearest vector search core
`ifndef NEAREST_VECTOR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_VECTOR_SEARCH_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define NVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define NVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nvs_pkg.sv =====
// Types and constants of the nearest vector search core
`default_nettype none

package nvs_pkg;

  localparam int FEATURE_PORTS = 10;
  localparam int FEATURE_COUNT = 10;
  localparam int MAX_SLOTS     = 256;

  localparam int FEAT_W  = 24;
  localparam int DIFF_W  = FEAT_W + 1;
  localparam int SQ_W    = 2 * FEAT_W;
  localparam int SUM_W   = 52;
  localparam int INDEX_W = 8;
  localparam int SLOT_W  = $clog2(MAX_SLOTS);

  localparam logic [SUM_W-1:0] LIMIT_RESET = 52'd655359868928000;

  localparam int TREE_LEVELS = $clog2(FEATURE_COUNT);
  localparam int PIPE_DEPTH  = 2 + TREE_LEVELS;
  localparam int FIFO_DEPTH  = PIPE_DEPTH + 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_CANDIDATE = 2'd1,
    OP_EMPTY     = 2'd2
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] winner_index;
    logic [SUM_W-1:0]   best_distance_sq;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/nvs_intf.sv =====
// Request, result and configuration channel interfaces
`default_nettype none

interface nvs_req_if;
  import nvs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [FEAT_W-1:0] feature_0;
  logic signed [FEAT_W-1:0] feature_1;
  logic signed [FEAT_W-1:0] feature_2;
  logic signed [FEAT_W-1:0] feature_3;
  logic signed [FEAT_W-1:0] feature_4;
  logic signed [FEAT_W-1:0] feature_5;
  logic signed [FEAT_W-1:0] feature_6;
  logic signed [FEAT_W-1:0] feature_7;
  logic signed [FEAT_W-1:0] feature_8;
  logic signed [FEAT_W-1:0] feature_9;
  logic                     last_slot;

  modport source (
    output valid, operation, feature_0, feature_1, feature_2, feature_3, feature_4,
           feature_5, feature_6, feature_7, feature_8, feature_9, last_slot,
    input  ready
  );
  modport sink (
    input  valid, operation, feature_0, feature_1, feature_2, feature_3, feature_4,
           feature_5, feature_6, feature_7, feature_8, feature_9, last_slot,
    output ready
  );
endinterface

interface nvs_res_if;
  import nvs_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] winner_index;
  logic [SUM_W-1:0]   best_distance_sq;

  modport source (output valid, found, winner_index, best_distance_sq, input ready);
  modport sink (input valid, found, winner_index, best_distance_sq, output ready);
endinterface

interface nvs_cfg_if;
  import nvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance_limit_sq;

  modport source (output valid, distance_limit_sq, input ready);
  modport sink (input valid, distance_limit_sq, output ready);
endinterface

`default_nettype wire

// ===== rtl/nvs_lane.sv =====
// One feature lane: registered difference, then registered square
`default_nettype none

module nvs_lane (
  input  logic                             clk_i,
  input  logic signed [nvs_pkg::FEAT_W-1:0] feature_i,
  input  logic signed [nvs_pkg::FEAT_W-1:0] ref_i,
  output logic [nvs_pkg::SQ_W-1:0]          sq_o
);
  import nvs_pkg::*;

  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic [FEAT_W-1:0]        mag;
  logic [SQ_W-1:0]          sq_d, sq_q;

  assign diff_d = DIFF_W'(feature_i) - DIFF_W'(ref_i);
  assign mag    = diff_q[DIFF_W-1] ? FEAT_W'(-diff_q) : FEAT_W'(diff_q);
  assign sq_d   = mag * mag;

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== rtl/nvs_merge.sv =====
// Registered adder tree that merges the lane squares into one distance
`default_nettype none

module nvs_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nvs_pkg::ctrl_t        ctrl_i,
  input  logic [nvs_pkg::SQ_W-1:0] sq_i [nvs_pkg::FEATURE_COUNT],
  output nvs_pkg::ctrl_t        ctrl_o,
  output logic [nvs_pkg::SUM_W-1:0] sum_o
);
  import nvs_pkg::*;

  logic [SUM_W-1:0] node_q [TREE_LEVELS+1][FEATURE_COUNT];
  ctrl_t            ctrl_q [TREE_LEVELS+1];

  assign ctrl_q[0] = ctrl_i;

  for (genvar j = 0; j < FEATURE_COUNT; j++) begin : g_leaf
    assign node_q[0][j] = SUM_W'(sq_i[j]);
  end

  for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_level
    localparam int NP = (FEATURE_COUNT + (1 << (l - 1)) - 1) >> (l - 1);
    localparam int NC = (FEATURE_COUNT + (1 << l) - 1) >> l;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[l] <= '0;
      end else begin
        ctrl_q[l] <= ctrl_q[l-1];
      end
    end

    for (genvar j = 0; j < FEATURE_COUNT; j++) begin : g_node
      if (j >= NC) begin : g_unused
        assign node_q[l][j] = '0;
      end else if (2 * j + 1 < NP) begin : g_add
        always_ff @(posedge clk_i) begin
          node_q[l][j] <= node_q[l-1][2*j] + node_q[l-1][2*j+1];
        end
      end else begin : g_pass
        always_ff @(posedge clk_i) begin
          node_q[l][j] <= node_q[l-1][2*j];
        end
      end
    end
  end

  assign ctrl_o = ctrl_q[TREE_LEVELS];
  assign sum_o  = node_q[TREE_LEVELS][0];

endmodule

`default_nettype wire

// ===== rtl/nvs_select.sv =====
// Running winner compare, slot counter and result formation
`default_nettype none

module nvs_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [nvs_pkg::SUM_W-1:0] limit_i,
  input  nvs_pkg::ctrl_t            ctrl_i,
  input  logic [nvs_pkg::SUM_W-1:0] sum_i,
  output logic                      push_o,
  output nvs_pkg::res_t             res_o
);
  import nvs_pkg::*;

  logic [SLOT_W-1:0] slot_d, slot_q;
  logic [SLOT_W-1:0] best_slot_d, best_slot_q;
  logic [SUM_W-1:0]  best_sum_d, best_sum_q;
  logic              have_d, have_q;

  always_comb begin
    slot_d      = slot_q;
    best_slot_d = best_slot_q;
    best_sum_d  = best_sum_q;
    have_d      = have_q;
    push_o      = 1'b0;
    res_o       = '0;
    if (ctrl_i.valid) begin
      if (ctrl_i.op == OP_LOAD) begin
        slot_d      = '0;
        best_slot_d = '0;
        have_d      = 1'b0;
      end else begin
        slot_d = (slot_q == SLOT_W'(MAX_SLOTS - 1)) ? '0 : slot_q + 1'b1;
        if (ctrl_i.op == OP_CANDIDATE && sum_i < limit_i &&
            (!have_q || sum_i < best_sum_q)) begin
          best_sum_d  = sum_i;
          best_slot_d = slot_q;
          have_d      = 1'b1;
        end
        if (ctrl_i.last) begin
          push_o                 = 1'b1;
          res_o.found            = have_d;
          res_o.winner_index     = have_d ? INDEX_W'(best_slot_d) : '0;
          res_o.best_distance_sq = have_d ? best_sum_d : limit_i;
          slot_d                 = '0;
          best_slot_d            = '0;
          have_d                 = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      best_slot_q <= '0;
      have_q      <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      best_slot_q <= best_slot_d;
      have_q      <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_sum_q <= best_sum_d;
  end

endmodule

`default_nettype wire

// ===== rtl/nvs_fifo.sv =====
// Result queue between the compare stage and the result channel
`default_nettype none

module nvs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nvs_pkg::res_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output nvs_pkg::res_t data_o
);
  import nvs_pkg::*;

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_d, wr_q, rd_d, rd_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nearest_vector_search_core.sv =====
// Nearest vector search core: takes one request per cycle. Each feature has its own lane that
// registers the difference to the stored reference and then its square; a four-level registered
// adder tree merges the ten squares, and a compare stage keeps the running winner and slot count.
// A last-slot result passes the lane registers and the tree levels; the compare stage then
// queues it. The request side stalls only when eight requests are outstanding (in the lanes,
// the tree or the result queue), so with the result side ready the rate is one request per cycle.
`default_nettype none
`include "nearest_vector_search_core_defines.svh"

module nearest_vector_search_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  nvs_cfg_if.sink    cfg_i,
  nvs_req_if.sink    req_i,
  nvs_res_if.source  res_o
);
  import nvs_pkg::*;

  logic [SUM_W-1:0]         limit_q;
  logic signed [FEAT_W-1:0] ref_q [FEATURE_COUNT];
  logic signed [FEAT_W-1:0] feat [FEATURE_PORTS];
  logic [SQ_W-1:0]          sq [FEATURE_COUNT];
  ctrl_t                    ctrl_s1_d, ctrl_s1_q, ctrl_s2_q, ctrl_m;
  logic [SUM_W-1:0]         sum_m;
  logic                     push;
  res_t                     res_d, res_q;
  logic                     acc, pop, drop;
  logic [CNT_W-1:0]         outstanding_d, outstanding_q;

  assign feat[0] = req_i.feature_0;
  assign feat[1] = req_i.feature_1;
  assign feat[2] = req_i.feature_2;
  assign feat[3] = req_i.feature_3;
  assign feat[4] = req_i.feature_4;
  assign feat[5] = req_i.feature_5;
  assign feat[6] = req_i.feature_6;
  assign feat[7] = req_i.feature_7;
  assign feat[8] = req_i.feature_8;
  assign feat[9] = req_i.feature_9;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (outstanding_q < CNT_W'(FIFO_DEPTH));
  assign acc         = req_i.valid && req_i.ready;
  assign pop         = res_o.valid && res_o.ready;
  assign drop        = ctrl_m.valid && !push;

  assign ctrl_s1_d = '{valid: acc, op: op_e'(req_i.operation), last: req_i.last_slot};
  assign outstanding_d = outstanding_q + CNT_W'(acc) - CNT_W'(drop) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= LIMIT_RESET;
      ctrl_s1_q     <= '0;
      ctrl_s2_q     <= '0;
      outstanding_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= cfg_i.distance_limit_sq;
      end
      ctrl_s1_q     <= ctrl_s1_d;
      ctrl_s2_q     <= ctrl_s1_q;
      outstanding_q <= outstanding_d;
    end
  end

  for (genvar i = 0; i < FEATURE_COUNT; i++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (acc && req_i.operation == OP_LOAD) begin
        ref_q[i] <= feat[i];
      end
    end

    nvs_lane u_lane (
      .clk_i     (clk_i),
      .feature_i (feat[i]),
      .ref_i     (ref_q[i]),
      .sq_o      (sq[i])
    );
  end

  nvs_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_s2_q),
    .sq_i   (sq),
    .ctrl_o (ctrl_m),
    .sum_o  (sum_m)
  );

  nvs_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .limit_i (limit_q),
    .ctrl_i  (ctrl_m),
    .sum_i   (sum_m),
    .push_o  (push),
    .res_o   (res_d)
  );

  nvs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_d),
    .pop_i   (pop),
    .valid_o (res_o.valid),
    .data_o  (res_q)
  );

  assign res_o.found            = res_q.found;
  assign res_o.winner_index     = res_q.winner_index;
  assign res_o.best_distance_sq = res_q.best_distance_sq;

  `NVS_ASSERT_NOW(a_credit_bound, 1'b1, outstanding_q <= CNT_W'(FIFO_DEPTH), "credit overrun")
  `NVS_ASSERT_NOW(a_found_below_limit, res_o.valid && res_o.found,
                  res_o.best_distance_sq < limit_q, "winner not below limit")
  `NVS_ASSERT_NOW(a_miss_reports_limit, res_o.valid && !res_o.found,
                  res_o.winner_index == '0 && res_o.best_distance_sq == limit_q,
                  "miss result malformed")
  `NVS_ASSERT_NEXT(a_held_result, res_o.valid && !res_o.ready,
                   res_o.valid && outstanding_q != '0, "pending result lost")

endmodule

`default_nettype wire
